// ===== src/als_pkg.sv =====
// ----------------------------------------------------------------------------
// als_pkg
// Shared types and constants for the alarm slot table.
// ----------------------------------------------------------------------------
package als_pkg;

   localparam int TYPE_W   = 8;
   localparam int MEMBER_W = 64;
   localparam int MODE_W   = 2;
   localparam int COUNT_W  = 4;
   localparam int COUNT_MAX = 15;

   localparam logic [MODE_W-1:0] MODE_ACTIVATE   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_DEACTIVATE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_QUERY      = 2'd2;

   localparam logic [MEMBER_W-1:0] MEMBER_DEFAULT = 64'd1;

   typedef struct packed {
      logic [MODE_W-1:0]   mode;
      logic [TYPE_W-1:0]   alarm_kind;
      logic [MEMBER_W-1:0] member_key;
   } als_req_type;

   typedef struct packed {
      logic               type_active;
      logic               table_changed;
      logic               dropped_full;
      logic [COUNT_W-1:0] active_count;
   } als_rsp_type;

endpackage

// ===== src/als_match.sv =====
// ----------------------------------------------------------------------------
// als_match
// Parallel slot compare: type hits, removable slots and the lowest free slot.
// ----------------------------------------------------------------------------
module als_match #(
   parameter int SLOTS = 8
) (
   input  logic [SLOTS-1:0]              slot_valid,
   input  logic [als_pkg::TYPE_W-1:0]    slot_type [SLOTS],
   input  logic [als_pkg::MEMBER_W-1:0]  slot_member [SLOTS],
   input  logic [als_pkg::TYPE_W-1:0]    alarm_kind,
   input  logic [als_pkg::MEMBER_W-1:0]  member_key,
   output logic [SLOTS-1:0]              hit,
   output logic [SLOTS-1:0]              kill,
   output logic [SLOTS-1:0]              free_first
);
   import als_pkg::*;

   logic [SLOTS-1:0] free_vec;

   always_comb begin
      for (int i = 0; i < SLOTS; i++) begin
         hit[i]  = slot_valid[i] && (slot_type[i] == alarm_kind);
         kill[i] = hit[i] && ((member_key == '0) || (slot_member[i] == member_key));
      end
   end

   assign free_vec   = ~slot_valid;
   assign free_first = free_vec & (~free_vec + {{(SLOTS-1){1'b0}}, 1'b1});

endmodule

// ===== src/alarm_slot_table.sv =====
// ----------------------------------------------------------------------------
// alarm_slot_table
// Associative table of raised alarms with activate, deactivate and query.
// ----------------------------------------------------------------------------
// Each request is captured in an input register and resolved against all SLOTS
// entries at once, so the block takes one request per cycle while rsp_stall does
// not hold the result register, and registers its answer word in that register.
// The pace is set by the combinational slot compare, free-slot priority encoder
// and valid count between the input register and the result register. The
// table is empty after reset.
module alarm_slot_table #(
   parameter int SLOTS = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  als_pkg::als_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output als_pkg::als_rsp_type rsp_data
);
   import als_pkg::*;

   localparam int CNT_W = $clog2(SLOTS + 1);

   logic                 req_valid_ff, req_valid_in;
   als_req_type          req_ff, req_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   als_rsp_type          rsp_ff, rsp_in;

   logic [SLOTS-1:0]     slot_valid_ff, slot_valid_in;
   logic [TYPE_W-1:0]    slot_type_ff [SLOTS];
   logic [TYPE_W-1:0]    slot_type_in [SLOTS];
   logic [MEMBER_W-1:0]  slot_member_ff [SLOTS];
   logic [MEMBER_W-1:0]  slot_member_in [SLOTS];

   logic [SLOTS-1:0]     hit, kill, free_first, kill_eff;
   logic                 advance, work, type_nz, is_act, is_deact;
   logic                 present, has_free, do_fill;
   logic [MEMBER_W-1:0]  fill_member;
   logic [CNT_W-1:0]     cnt;
   logic [31:0]          cnt_wide;

   als_match #(.SLOTS(SLOTS)) u_match (
      .slot_valid  (slot_valid_ff),
      .slot_type   (slot_type_ff),
      .slot_member (slot_member_ff),
      .alarm_kind  (req_ff.alarm_kind),
      .member_key  (req_ff.member_key),
      .hit         (hit),
      .kill        (kill),
      .free_first  (free_first)
   );

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = req_valid_ff && !advance;
   assign work      = req_valid_ff && advance;

   assign type_nz  = (req_ff.alarm_kind != '0);
   assign is_act   = (req_ff.mode == MODE_ACTIVATE);
   assign is_deact = (req_ff.mode == MODE_DEACTIVATE);
   assign present  = |hit;
   assign has_free = |free_first;
   assign do_fill  = is_act && type_nz && !present && has_free;
   assign kill_eff = (is_deact && type_nz) ? kill : '0;
   assign fill_member = (req_ff.member_key != '0) ? req_ff.member_key : MEMBER_DEFAULT;

   always_comb begin
      for (int i = 0; i < SLOTS; i++) begin
         slot_valid_in[i]  = slot_valid_ff[i];
         slot_type_in[i]   = slot_type_ff[i];
         slot_member_in[i] = slot_member_ff[i];
         if (do_fill && free_first[i]) begin
            slot_valid_in[i]  = 1'b1;
            slot_type_in[i]   = req_ff.alarm_kind;
            slot_member_in[i] = fill_member;
         end else if (kill_eff[i]) begin
            slot_valid_in[i]  = 1'b0;
            slot_type_in[i]   = '0;
            slot_member_in[i] = '0;
         end
      end
   end

   always_comb begin
      cnt = '0;
      for (int i = 0; i < SLOTS; i++) begin
         cnt = cnt + CNT_W'(slot_valid_in[i]);
      end
      cnt_wide = 32'(cnt);
   end

   always_comb begin
      rsp_in.table_changed = do_fill || (|kill_eff);
      rsp_in.dropped_full  = is_act && type_nz && !present && !has_free;
      rsp_in.active_count  = (cnt_wide > 32'(COUNT_MAX)) ? COUNT_W'(COUNT_MAX)
                                                         : cnt_wide[COUNT_W-1:0];
      if (is_act) begin
         rsp_in.type_active = type_nz && (present || has_free);
      end else if (is_deact) begin
         rsp_in.type_active = |(hit & ~kill_eff);
      end else begin
         rsp_in.type_active = present;
      end
   end

   assign req_valid_in = req_stall ? 1'b1 : req_valid;
   assign req_in       = (req_valid && !req_stall) ? req_data : req_ff;
   assign rsp_valid_in = advance ? req_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         slot_valid_ff <= '0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (work) begin
            slot_valid_ff <= slot_valid_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      if (work) begin
         rsp_ff <= rsp_in;
         for (int i = 0; i < SLOTS; i++) begin
            slot_type_ff[i]   <= slot_type_in[i];
            slot_member_ff[i] <= slot_member_in[i];
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== sim/tb_alarm_slot_table.sv =====
// ----------------------------------------------------------------------------
// tb_alarm_slot_table
// Self-checking testbench for the alarm slot table.
// ----------------------------------------------------------------------------
// A scoreboard keeps its own copy of the slots and works out the answer to
// every accepted request. Each answer word is compared field by field with the
// oldest pending answer. A short directed sequence comes first, then random
// requests drawn mostly from small pools of types and members so that the table
// fills, drains and collides. Both sides idle at random, and the receiver once
// holds off long enough for the block to back up its input.
// ----------------------------------------------------------------------------
module tb_alarm_slot_table;
   timeunit 1ns;
   timeprecision 1ps;

   import als_pkg::*;

   localparam int SLOTS = 8;
   localparam int RANDOM_WORDS = 800;
   localparam int IDLE_LIMIT = 2000;
   localparam int HOLD_CYCLES = 64;
   localparam int HOLD_AFTER = 400;
   localparam int DRAIN_CYCLES = 8;
   localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

   class alarm_tracker;
      logic                slot_used [SLOTS];
      logic [TYPE_W-1:0]   slot_kind [SLOTS];
      logic [MEMBER_W-1:0] slot_owner [SLOTS];
      als_rsp_type         pending_rsp [$];
      int unsigned         error_count;

      function new();
         int i;
         for (i = 0; i < SLOTS; i++) begin
            slot_used[i] = 1'b0;
            slot_kind[i] = '0;
            slot_owner[i] = '0;
         end
         error_count = 0;
      endfunction

      function logic type_held(logic [TYPE_W-1:0] kind);
         int i;
         type_held = 1'b0;
         for (i = 0; i < SLOTS; i++) begin
            if (slot_used[i] && slot_kind[i] == kind) begin
               type_held = 1'b1;
            end
         end
      endfunction

      function als_rsp_type predict_response(als_req_type req);
         als_rsp_type rsp;
         logic        changed;
         logic        dropped;
         int          free_idx;
         int          used;
         int          i;
         changed = 1'b0;
         dropped = 1'b0;
         free_idx = -1;
         used = 0;
         if (req.mode == MODE_ACTIVATE && req.alarm_kind != '0
             && !type_held(req.alarm_kind)) begin
            for (i = SLOTS - 1; i >= 0; i--) begin
               if (!slot_used[i]) begin
                  free_idx = i;
               end
            end
            if (free_idx >= 0) begin
               slot_used[free_idx] = 1'b1;
               slot_kind[free_idx] = req.alarm_kind;
               slot_owner[free_idx] = (req.member_key != '0) ? req.member_key
                                                             : MEMBER_DEFAULT;
               changed = 1'b1;
            end else begin
               dropped = 1'b1;
            end
         end else if (req.mode == MODE_DEACTIVATE && req.alarm_kind != '0) begin
            for (i = 0; i < SLOTS; i++) begin
               if (slot_used[i] && slot_kind[i] == req.alarm_kind
                   && (req.member_key == '0 || slot_owner[i] == req.member_key)) begin
                  slot_used[i] = 1'b0;
                  slot_kind[i] = '0;
                  slot_owner[i] = '0;
                  changed = 1'b1;
               end
            end
         end
         for (i = 0; i < SLOTS; i++) begin
            if (slot_used[i]) begin
               used++;
            end
         end
         rsp.type_active = type_held(req.alarm_kind);
         rsp.table_changed = changed;
         rsp.dropped_full = dropped;
         rsp.active_count = (used > COUNT_MAX) ? COUNT_W'(COUNT_MAX) : COUNT_W'(used);
         return rsp;
      endfunction

      function void note_request(als_req_type req);
         pending_rsp.push_back(predict_response(req));
      endfunction

      function void check_response(als_rsp_type got);
         als_rsp_type want;
         if (pending_rsp.size() == 0) begin
            $error("unexpected result word %h", got);
            error_count++;
            return;
         end
         want = pending_rsp.pop_front();
         if (got.type_active !== want.type_active) begin
            $error("type_active: expected %0d, got %0d", want.type_active, got.type_active);
            error_count++;
         end
         if (got.table_changed !== want.table_changed) begin
            $error("table_changed: expected %0d, got %0d",
                   want.table_changed, got.table_changed);
            error_count++;
         end
         if (got.dropped_full !== want.dropped_full) begin
            $error("dropped_full: expected %0d, got %0d",
                   want.dropped_full, got.dropped_full);
            error_count++;
         end
         if (got.active_count !== want.active_count) begin
            $error("active_count: expected %0d, got %0d",
                   want.active_count, got.active_count);
            error_count++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   als_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   als_rsp_type rsp_data;

   alarm_tracker tracker = new();
   int unsigned  results_seen = 0;
   int unsigned  idle_cycles = 0;
   int unsigned  req_max_gap = 4;
   int unsigned  rsp_max_stall = 4;
   bit           hold_active = 1'b0;
   bit           hold_done = 1'b0;

   alarm_slot_table #(
      .SLOTS(SLOTS)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            tracker.note_request(req_data);
         end
         if (rsp_valid && !rsp_stall) begin
            tracker.check_response(rsp_data);
            results_seen++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_word(input logic [MODE_W-1:0] mode,
                            input logic [TYPE_W-1:0] kind,
                            input logic [MEMBER_W-1:0] member);
      als_req_type word;
      int unsigned gap;
      word.mode = mode;
      word.alarm_kind = kind;
      word.member_key = member;
      gap = hold_active ? 0 : $urandom_range(0, req_max_gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= word;
      do @(posedge clock); while (req_stall);
   endtask

   initial begin : receiver
      int unsigned pause;
      forever begin
         if (!hold_done && results_seen >= HOLD_AFTER) begin
            hold_active = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
            hold_active = 1'b0;
            hold_done = 1'b1;
         end else begin
            pause = $urandom_range(0, rsp_max_stall);
            if (pause > 0) begin
               rsp_stall <= 1'b1;
               repeat (pause) @(posedge clock);
               rsp_stall <= 1'b0;
            end
         end
         do @(posedge clock); while (!rsp_valid);
      end
   end

   initial begin : stimulus
      logic [MODE_W-1:0]   mode;
      logic [TYPE_W-1:0]   kind;
      logic [MEMBER_W-1:0] member;
      logic [MEMBER_W-1:0] recent_member;
      int unsigned         pick;
      int                  n;

      recent_member = MEMBER_DEFAULT;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_word(MODE_QUERY, 8'd0, '0);
      send_word(MODE_ACTIVATE, 8'd0, 64'd5);
      send_word(MODE_DEACTIVATE, 8'd0, '0);
      send_word(MODE_ACTIVATE, 8'd1, '0);
      send_word(MODE_ACTIVATE, 8'd1, 64'd7);
      send_word(MODE_DEACTIVATE, 8'd1, 64'd2);
      send_word(MODE_DEACTIVATE, 8'd1, 64'd1);
      send_word(MODE_ACTIVATE, 8'hFF, '1);
      for (n = 2; n <= 8; n++) begin
         send_word(MODE_ACTIVATE, 8'(n), 64'(n) << 56);
      end
      send_word(MODE_ACTIVATE, 8'd9, 64'd9);
      send_word(MODE_SPARE, 8'hFF, 64'd3);
      send_word(MODE_QUERY, 8'hFF, '1);
      send_word(MODE_DEACTIVATE, 8'hFF, '0);
      send_word(MODE_QUERY, 8'hFF, '0);
      send_word(MODE_DEACTIVATE, 8'd3, 64'd3 << 56);

      for (n = 0; n < RANDOM_WORDS; n++) begin
         if (n % 100 == 0) begin
            req_max_gap = ($urandom_range(0, 2) == 0) ? 0 : 4;
            rsp_max_stall = ($urandom_range(0, 2) == 0) ? 0 : 4;
         end
         pick = $urandom_range(0, 19);
         if (pick < 8) begin
            mode = MODE_ACTIVATE;
         end else if (pick < 15) begin
            mode = MODE_DEACTIVATE;
         end else if (pick < 19) begin
            mode = MODE_QUERY;
         end else begin
            mode = MODE_SPARE;
         end
         pick = $urandom_range(0, 9);
         if (pick == 0) begin
            kind = '0;
         end else if (pick == 1) begin
            kind = TYPE_W'($urandom_range(0, 255));
         end else begin
            kind = TYPE_W'($urandom_range(1, 12));
         end
         case ($urandom_range(0, 7))
            0: begin
               member = '0;
            end
            1, 2: begin
               member = 64'd1;
            end
            3: begin
               member = 64'd2;
            end
            4, 5: begin
               member = recent_member;
            end
            default: begin
               member = {$urandom, $urandom};
            end
         endcase
         if (mode == MODE_ACTIVATE && member != '0) begin
            recent_member = member;
         end
         send_word(mode, kind, member);
      end
      req_valid <= 1'b0;

      while (tracker.pending_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tracker.pending_rsp.size() != 0) begin
         $error("%0d expected result words never arrived", tracker.pending_rsp.size());
         tracker.error_count++;
      end
      if (tracker.error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
